[design/toaf_pkg.sv]
// ----------------------------------------------------------------------------
// toaf_pkg
// Types, codes and constants shared by the two-operand ALU step.
// ----------------------------------------------------------------------------
package toaf_pkg;

  localparam int unsigned QueueDepth = 2;

  localparam logic [16:0] TextSizeReset  = 17'h10000;
  localparam logic [15:0] BreakSizeReset = 16'h0000;
  localparam logic [15:0] SetdWord       = 16'o170011;

  typedef enum logic [0:0] {
    CFG_TEXT_SIZE  = 1'b0,
    CFG_BREAK_SIZE = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    WK_NONE = 2'd0,
    WK_WORD = 2'd1,
    WK_BYTE = 2'd2
  } write_kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_OVERRUN  = 3'd1,
    ST_STACK_OV = 3'd2,
    ST_NOT_IMPL = 3'd3,
    ST_HALTED   = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ALU_NONE = 3'd0,
    ALU_MOV  = 3'd1,
    ALU_CMP  = 3'd2,
    ALU_BIT  = 3'd3,
    ALU_BIC  = 3'd4,
    ALU_BIS  = 3'd5,
    ALU_ADD  = 3'd6,
    ALU_SUB  = 3'd7
  } alu_op_t;

  typedef struct packed {
    logic [15:0] instruction_word;
    logic [15:0] instruction_address;
    logic [2:0]  instruction_length;
    logic [15:0] stack_pointer;
    logic [15:0] source_value;
    logic [15:0] destination_value;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result_value;
    write_kind_t write_kind;
    logic [15:0] next_address;
    logic        negative_flag;
    logic        zero_flag;
    logic        overflow_flag;
    logic        carry_flag;
    status_t     status;
  } out_item_t;

  typedef struct packed {
    alu_op_t     op;
    logic        byte_op;
    status_t     status;
    logic [15:0] next_address;
    logic [15:0] src;
    logic [15:0] dst;
  } cmd_t;

  typedef struct packed {
    logic n;
    logic z;
    logic v;
    logic c;
  } flags_t;

endpackage

[design/toaf_front.sv]
// ----------------------------------------------------------------------------
// toaf_front
// Takes instructions, checks overrun and stack limit, decodes the opcode
// and keeps the halt state.
// ----------------------------------------------------------------------------
module toaf_front import toaf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  input  in_item_t    in_data,
  output logic        in_stall,
  output logic        cmd_valid,
  output cmd_t        cmd,
  input  logic        cmd_full
);

  logic [16:0] text_size_r, text_size_nxt;
  logic [15:0] break_size_r, break_size_nxt;
  logic        halted_r, halted_nxt;
  logic        accept;
  logic [16:0] end_addr;
  logic        overrun, stack_ov;

  assign in_stall  = cmd_full;
  assign cmd_valid = in_valid;
  assign accept    = in_valid && !cmd_full;

  assign end_addr = {1'b0, in_data.instruction_address} + {14'd0, in_data.instruction_length};
  assign overrun  = end_addr > text_size_r;
  assign stack_ov = in_data.stack_pointer < break_size_r;

  always_comb begin
    cmd.src          = in_data.source_value;
    cmd.dst          = in_data.destination_value;
    // sub sits in the byte half of the opcode space but is a word operation
    cmd.byte_op      = in_data.instruction_word[15] &&
                       (in_data.instruction_word[15:12] != 4'o16);
    cmd.op           = ALU_NONE;
    cmd.status       = ST_OK;
    cmd.next_address = in_data.instruction_address;
    priority if (halted_r) begin
      cmd.status = ST_HALTED;
    end else if (overrun) begin
      cmd.status = ST_OVERRUN;
    end else if (stack_ov) begin
      cmd.status = ST_STACK_OV;
    end else begin
      cmd.next_address = end_addr[15:0];
      unique case (in_data.instruction_word[15:12])
        4'o01, 4'o11: cmd.op = ALU_MOV;
        4'o02, 4'o12: cmd.op = ALU_CMP;
        4'o03, 4'o13: cmd.op = ALU_BIT;
        4'o04, 4'o14: cmd.op = ALU_BIC;
        4'o05, 4'o15: cmd.op = ALU_BIS;
        4'o06:        cmd.op = ALU_ADD;
        4'o16:        cmd.op = ALU_SUB;
        default: begin
          if (in_data.instruction_word != SetdWord) begin
            cmd.status = ST_NOT_IMPL;
          end
        end
      endcase
    end
  end

  always_comb begin
    text_size_nxt  = text_size_r;
    break_size_nxt = break_size_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TEXT_SIZE:  text_size_nxt  = cfg_wdata;
        CFG_BREAK_SIZE: break_size_nxt = cfg_wdata[15:0];
      endcase
    end
  end

  assign halted_nxt = halted_r || (accept && cmd.status != ST_OK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_size_r  <= TextSizeReset;
      break_size_r <= BreakSizeReset;
      halted_r     <= 1'b0;
    end else begin
      text_size_r  <= text_size_nxt;
      break_size_r <= break_size_nxt;
      halted_r     <= halted_nxt;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt state cleared without reset");

  a_halted_status: assert property (@(posedge clk) disable iff (!rst_n)
    accept && halted_r |-> cmd.status == ST_HALTED && cmd.op == ALU_NONE)
    else $error("transaction after halt not marked as halted");

endmodule

[design/toaf_queue.sv]
// ----------------------------------------------------------------------------
// toaf_queue
// Short command queue between decode and execute.
// ----------------------------------------------------------------------------
module toaf_queue import toaf_pkg::*; #(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  cmd_t push_data,
  output logic full,
  output logic pop_valid,
  output cmd_t pop_data,
  input  logic pop_ready
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          push, pop;

  assign full      = count_r == CW'(DEPTH);
  assign pop_valid = count_r != '0;
  assign push      = push_valid && !full;
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem_r[rd_ptr_r];

  assign wr_ptr_nxt = !push ? wr_ptr_r :
                      (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_ptr_nxt = !pop ? rd_ptr_r :
                      (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  always_comb begin
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue occupancy beyond depth");

endmodule

[design/toaf_back.sv]
// ----------------------------------------------------------------------------
// toaf_back
// Executes queued commands, holds the condition codes and the output
// register.
// ----------------------------------------------------------------------------
module toaf_back import toaf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_ready,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  flags_t      flags_r, flags_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_data_r, out_data_nxt;
  logic        pop;
  logic [15:0] a, b, res, res_m, vx;
  logic [16:0] wide;
  logic        upd, c_new, v_calc;
  write_kind_t kind;

  assign cmd_ready = !out_valid_r || !out_stall;
  assign pop       = cmd_valid && cmd_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    a      = cmd.byte_op ? {8'h00, cmd.src[7:0]} : cmd.src;
    b      = cmd.byte_op ? {8'h00, cmd.dst[7:0]} : cmd.dst;
    wide   = '0;
    res    = '0;
    vx     = '0;
    upd    = 1'b1;
    v_calc = 1'b0;
    c_new  = flags_r.c;
    kind   = WK_NONE;
    unique case (cmd.op)
      ALU_NONE: upd = 1'b0;
      ALU_MOV: begin
        res  = a;
        kind = cmd.byte_op ? WK_BYTE : WK_WORD;
      end
      ALU_CMP: begin
        wide   = {1'b0, a} - {1'b0, b};
        res    = wide[15:0];
        c_new  = wide[16];
        v_calc = 1'b1;
      end
      ALU_BIT: res = a & b;
      ALU_BIC: begin
        res  = ~a & b;
        kind = cmd.byte_op ? WK_BYTE : WK_WORD;
      end
      ALU_BIS: begin
        res  = a | b;
        kind = cmd.byte_op ? WK_BYTE : WK_WORD;
      end
      ALU_ADD: begin
        wide  = {1'b0, a} + {1'b0, b};
        res   = wide[15:0];
        c_new = wide[16];
        kind  = WK_WORD;
      end
      ALU_SUB: begin
        wide  = {1'b0, b} - {1'b0, a};
        res   = wide[15:0];
        c_new = wide[16];
        kind  = WK_WORD;
      end
    endcase
    res_m = cmd.byte_op ? {8'h00, res[7:0]} : res;
    unique case (cmd.op)
      ALU_ADD: vx = ~(a ^ b) & (a ^ res_m);
      ALU_SUB: vx = (b ^ a) & (b ^ res_m);
      default: vx = (a ^ b) & (a ^ res_m);
    endcase
    flags_nxt = flags_r;
    if (upd) begin
      flags_nxt.n = cmd.byte_op ? res_m[7] : res_m[15];
      flags_nxt.z = res_m == '0;
      flags_nxt.v = (v_calc || cmd.op == ALU_ADD || cmd.op == ALU_SUB) &&
                    (cmd.byte_op ? vx[7] : vx[15]);
      flags_nxt.c = c_new;
    end
    out_data_nxt.result_value  = upd ? res_m : 16'h0000;
    out_data_nxt.write_kind    = kind;
    out_data_nxt.next_address  = cmd.next_address;
    out_data_nxt.negative_flag = flags_nxt.n;
    out_data_nxt.zero_flag     = flags_nxt.z;
    out_data_nxt.overflow_flag = flags_nxt.v;
    out_data_nxt.carry_flag    = flags_nxt.c;
    out_data_nxt.status        = cmd.status;
  end

  assign out_valid_nxt = pop || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (pop) begin
        flags_r <= flags_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= out_data_nxt;
    end
  end

  a_write_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.write_kind != WK_NONE |-> out_data_r.status == ST_OK)
    else $error("write-back on a faulted transaction");

  a_flags_held: assert property (@(posedge clk) disable iff (!rst_n)
    pop && cmd.op == ALU_NONE |=> flags_r == $past(flags_r))
    else $error("condition codes changed by a no-op transaction");

endmodule

[design/two_operand_alu_flags_step.sv]
// ----------------------------------------------------------------------------
// two_operand_alu_flags_step
// Executes one double-operand instruction per transaction and reports
// result, write-back kind, condition codes, next address and status.
// ----------------------------------------------------------------------------
// Sustains one instruction per clock while the output is not stalled. Each
// instruction taken is decoded and limit-checked, then written into a command
// queue of QUEUE_DEPTH entries, and the execute stage loads the output
// register as it leaves the queue. Input stalls only when the queue is full.
// After an overrun, a stack overflow or an unknown opcode every later
// instruction answers "already halted" until reset. The user must write the
// registers only while no transaction is in flight; the block itself does
// not enforce this.
module two_operand_alu_flags_step import toaf_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  cfg_idx_t    cfg_index,
  input  logic [16:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data
);

  logic cmd_push_valid, q_full, q_valid, q_ready;
  cmd_t cmd_in, cmd_out;

  toaf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cmd_valid (cmd_push_valid),
    .cmd       (cmd_in),
    .cmd_full  (q_full)
  );

  toaf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (cmd_push_valid),
    .push_data  (cmd_in),
    .full       (q_full),
    .pop_valid  (q_valid),
    .pop_data   (cmd_out),
    .pop_ready  (q_ready)
  );

  toaf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_valid),
    .cmd       (cmd_out),
    .cmd_ready (q_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
